@@ design/mono_lcd_framebuffer_engine_unit_assert.svh @@
// Assertion helpers for the RTL files, included by mlfe_back.sv.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef MONO_LCD_FRAMEBUFFER_ENGINE_UNIT_ASSERT_SVH
`define MONO_LCD_FRAMEBUFFER_ENGINE_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MLFE_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MLFE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mlfe_pkg.sv @@
package mlfe_pkg;

    localparam int COLUMNS     = 84;
    localparam int STORE_BYTES = 504;
    localparam int GLYPH_WIDTH = 5;

    localparam int BANKS      = STORE_BYTES / COLUMNS;
    localparam int ROWS       = BANKS * 8;
    localparam int CELL_BYTES = GLYPH_WIDTH + 1;
    localparam int ADDR_W     = $clog2(STORE_BYTES);
    localparam int CUR_W      = $clog2(STORE_BYTES + 1);

    localparam int FQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    localparam logic [7:0] CHAR_FIRST   = 8'h20;
    localparam logic [7:0] CHAR_LAST    = 8'h7F;
    localparam logic [7:0] LCD_FUNC_SET = 8'h20;
    localparam logic [7:0] LCD_SET_Y    = 8'h40;
    localparam logic [7:0] LCD_SET_X    = 8'h80;

    typedef enum logic [2:0] {
        OP_SET, OP_CLR, OP_DRAW, OP_ERASE, OP_CHAR, OP_MOVE, OP_CLEAR, OP_READ
    } t_op;

    typedef enum logic [1:0] {
        ST_OK, ST_COORD, ST_CHAR, ST_OVERFLOW
    } t_status;

    typedef struct packed {
        t_op               op;
        t_status           status;
        logic [6:0]        x1;
        logic [5:0]        y1;
        logic [6:0]        x2;
        logic [5:0]        y2;
        logic [7:0]        code;
        logic [ADDR_W-1:0] addr;
    } t_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       last;
        t_status    status;
    } t_result;

    // One glyph per entry, leftmost column in the top byte.
    localparam logic [8*GLYPH_WIDTH-1:0] FONT [96] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
    };

    // Column col (0 is leftmost, below GLYPH_WIDTH) of a printable character.
    function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
        logic [6:0] idx;
        logic [8*GLYPH_WIDTH-1:0] row;
        idx = 7'(code - CHAR_FIRST);
        row = FONT[idx] >> (8 * (GLYPH_WIDTH - 1 - int'(col)));
        return row[7:0];
    endfunction

endpackage

@@ design/mlfe_front.sv @@
module mlfe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_command,
    input  logic [6:0]       i_x_first,
    input  logic [5:0]       i_y_first,
    input  logic [6:0]       i_x_second,
    input  logic [5:0]       i_y_second,
    input  logic [7:0]       i_glyph_code,
    input  logic [8:0]       i_read_address,
    input  logic             i_pop,
    output logic             o_valid,
    output mlfe_pkg::t_item  o_item
);
    import mlfe_pkg::*;

    localparam int PTR_W = $clog2(FQ_DEPTH);

    t_item             w_item;
    logic              w_x1_bad, w_y1_bad, w_x2_bad, w_y2_bad;
    t_item             r_q [FQ_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_cnt;
    logic              w_wr, w_rd;

    // Range checks that do not depend on block state are settled here.
    always_comb begin
        w_x1_bad = int'(i_x_first) >= COLUMNS;
        w_y1_bad = int'(i_y_first) >= ROWS;
        w_x2_bad = int'(i_x_second) >= COLUMNS;
        w_y2_bad = int'(i_y_second) >= ROWS;
        w_item.op     = t_op'(i_command);
        w_item.x1     = i_x_first;
        w_item.y1     = i_y_first;
        w_item.x2     = i_x_second;
        w_item.y2     = i_y_second;
        w_item.code   = i_glyph_code;
        w_item.addr   = ADDR_W'(i_read_address);
        w_item.status = ST_OK;
        unique case (w_item.op)
            OP_SET, OP_CLR: begin
                if (w_x1_bad || w_y1_bad) w_item.status = ST_COORD;
            end
            OP_DRAW, OP_ERASE: begin
                if (w_x1_bad || w_y1_bad || w_x2_bad || w_y2_bad) w_item.status = ST_COORD;
            end
            OP_CHAR: begin
                if (i_glyph_code < CHAR_FIRST || i_glyph_code > CHAR_LAST) begin
                    w_item.status = ST_CHAR;
                end
            end
            OP_MOVE: begin
                if (w_x1_bad || int'(i_y_first) >= BANKS) w_item.status = ST_COORD;
            end
            OP_CLEAR: w_item.status = ST_OK;
            OP_READ: begin
                if (int'(i_read_address) >= STORE_BYTES) w_item.status = ST_COORD;
            end
            default: w_item.status = ST_OK;
        endcase
    end

    assign o_full  = (int'(r_cnt) == FQ_DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= r_cnt + (PTR_W + 1)'(w_wr) - (PTR_W + 1)'(w_rd);
        end
    end

endmodule

@@ design/mlfe_back.sv @@
`include "mono_lcd_framebuffer_engine_unit_assert.svh"

module mlfe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mlfe_pkg::t_item    i_item,
    output logic               o_pop,
    input  logic               i_out_full,
    output logic               o_push,
    output mlfe_pkg::t_result  o_result,
    output logic               o_init
);
    import mlfe_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_PIX_RD, S_PIX_WR, S_CHAR, S_MOVE,
        S_CLEAR, S_READ_RD, S_READ_OUT, S_DONE
    } t_state;

    t_state             r_state;
    t_item              r_item;
    t_status            r_status;
    logic [CUR_W-1:0]   r_cursor;
    logic [ADDR_W-1:0]  r_cnt;
    logic [ADDR_W-1:0]  r_waddr;
    logic [2:0]         r_bit;
    logic               r_vert, r_sel;
    logic [6:0]         r_i;
    logic [7:0]         r_mem [STORE_BYTES];
    logic [7:0]         r_rdata;

    logic               w_single, w_on, w_want;
    logic [6:0]         w_px;
    logic [5:0]         w_py;
    logic [ADDR_W-1:0]  w_pix_addr, w_rd_addr, w_addr;
    logic               w_wen;
    logic [7:0]         w_wdata, w_mask, w_char_byte;

    always_comb begin
        w_single = (r_item.op == OP_SET) || (r_item.op == OP_CLR);
        w_on     = (r_item.op == OP_SET) || (r_item.op == OP_DRAW);
        if (w_single) begin
            w_px = r_item.x1;
            w_py = r_item.y1;
        end else if (r_vert) begin
            w_px = r_sel ? r_item.x2 : r_item.x1;
            w_py = r_i[5:0];
        end else begin
            w_px = r_i;
            w_py = r_sel ? r_item.y2 : r_item.y1;
        end
        w_pix_addr  = ADDR_W'(int'(w_py[5:3]) * COLUMNS + int'(w_px));
        w_mask      = 8'(1) << r_bit;
        w_char_byte = (int'(r_cnt) < GLYPH_WIDTH) ? glyph_col(r_item.code, r_cnt[2:0]) : 8'h00;
    end

    always_comb begin
        unique case (r_state)
            S_PIX_RD: w_rd_addr = w_pix_addr;
            S_PIX_WR: w_rd_addr = r_waddr;
            default:  w_rd_addr = r_item.addr;
        endcase
    end

    always_comb begin
        w_wen   = 1'b0;
        w_addr  = r_cnt;
        w_wdata = 8'h00;
        unique case (r_state)
            S_INIT, S_CLEAR: w_wen = 1'b1;
            S_PIX_WR: begin
                w_wen   = 1'b1;
                w_addr  = r_waddr;
                w_wdata = w_on ? (r_rdata | w_mask) : (r_rdata & ~w_mask);
            end
            S_CHAR: begin
                w_wen   = !i_out_full;
                w_addr  = ADDR_W'(r_cursor + CUR_W'(r_cnt));
                w_wdata = w_char_byte;
            end
            default: w_wen = 1'b0;
        endcase
    end

    always_comb begin
        w_want   = 1'b0;
        o_result = '{data_byte: 8'h00, is_data: 1'b0, last: 1'b1, status: ST_OK};
        unique case (r_state)
            S_CHAR: begin
                w_want   = 1'b1;
                o_result = '{data_byte: w_char_byte, is_data: 1'b1,
                             last: (int'(r_cnt) == CELL_BYTES - 1), status: ST_OK};
            end
            S_MOVE: begin
                w_want = 1'b1;
                o_result.last = (r_cnt == ADDR_W'(2));
                if (r_cnt == '0) begin
                    o_result.data_byte = LCD_FUNC_SET;
                end else if (r_cnt == ADDR_W'(1)) begin
                    o_result.data_byte = LCD_SET_Y | 8'(r_item.y1);
                end else begin
                    o_result.data_byte = LCD_SET_X | 8'(r_item.x1);
                end
            end
            S_READ_OUT: begin
                w_want   = 1'b1;
                o_result = '{data_byte: r_rdata, is_data: 1'b1, last: 1'b1, status: ST_OK};
            end
            S_DONE: begin
                w_want   = 1'b1;
                o_result = '{data_byte: 8'h00, is_data: (r_item.op == OP_READ),
                             last: 1'b1, status: r_status};
            end
            default: w_want = 1'b0;
        endcase
    end

    assign o_push = w_want && !i_out_full;
    assign o_pop  = (r_state == S_IDLE) && i_valid;
    assign o_init = (r_state == S_INIT);

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_cursor <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    if (int'(r_cnt) == STORE_BYTES - 1) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_item   <= i_item;
                        r_status <= i_item.status;
                        r_cnt    <= '0;
                        r_sel    <= 1'b0;
                        r_vert   <= 1'b0;
                        r_i      <= i_item.x1;
                        if (i_item.status != ST_OK) begin
                            r_state <= S_DONE;
                        end else begin
                            unique case (i_item.op)
                                OP_SET, OP_CLR: r_state <= S_PIX_RD;
                                OP_DRAW, OP_ERASE: begin
                                    if (i_item.x1 <= i_item.x2) begin
                                        r_state <= S_PIX_RD;
                                    end else if (i_item.y1 <= i_item.y2) begin
                                        r_vert  <= 1'b1;
                                        r_i     <= 7'(i_item.y1);
                                        r_state <= S_PIX_RD;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                                OP_CHAR: begin
                                    if (int'(r_cursor) > STORE_BYTES - CELL_BYTES) begin
                                        r_status <= ST_OVERFLOW;
                                        r_state  <= S_DONE;
                                    end else begin
                                        r_state <= S_CHAR;
                                    end
                                end
                                OP_MOVE:  r_state <= S_MOVE;
                                OP_CLEAR: r_state <= S_CLEAR;
                                OP_READ:  r_state <= S_READ_RD;
                                default:  r_state <= S_DONE;
                            endcase
                        end
                    end
                end
                S_PIX_RD: begin
                    r_waddr <= w_pix_addr;
                    r_bit   <= w_py[2:0];
                    r_state <= S_PIX_WR;
                end
                S_PIX_WR: begin
                    if (w_single) begin
                        r_state <= S_DONE;
                    end else if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= S_PIX_RD;
                    end else if (!r_vert) begin
                        r_sel <= 1'b0;
                        if (r_i == r_item.x2) begin
                            if (r_item.y1 <= r_item.y2) begin
                                r_vert  <= 1'b1;
                                r_i     <= 7'(r_item.y1);
                                r_state <= S_PIX_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PIX_RD;
                        end
                    end else begin
                        r_sel <= 1'b0;
                        if (r_i == 7'(r_item.y2)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PIX_RD;
                        end
                    end
                end
                S_CHAR: begin
                    if (!i_out_full) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (int'(r_cnt) == CELL_BYTES - 1) begin
                            r_cursor <= r_cursor + CUR_W'(CELL_BYTES);
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_MOVE: begin
                    if (!i_out_full) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == ADDR_W'(2)) begin
                            r_cursor <= CUR_W'(int'(r_item.x1) + int'(r_item.y1) * COLUMNS);
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_CLEAR: begin
                    if (int'(r_cnt) == STORE_BYTES - 1) begin
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_READ_RD: r_state <= S_READ_OUT;
                S_READ_OUT: begin
                    if (!i_out_full) r_state <= S_IDLE;
                end
                S_DONE: begin
                    if (!i_out_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MLFE_ASSERT_SAME(a_wr_in_store, w_wen, int'(w_addr) < STORE_BYTES, "store write out of range")
    `MLFE_ASSERT_SAME(a_cursor_bound, 1'b1, int'(r_cursor) <= STORE_BYTES, "cursor past store")
    `MLFE_ASSERT_NEXT(a_rmw_pair, r_state == S_PIX_RD, r_state == S_PIX_WR, "pixel read not followed by write")

endmodule

@@ design/mlfe_outq.sv @@
module mlfe_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mlfe_pkg::t_result  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output mlfe_pkg::t_result  o_data
);
    import mlfe_pkg::*;

    localparam int PTR_W = $clog2(OQ_DEPTH);

    t_result           r_q [OQ_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_cnt;
    logic              w_wr, w_rd;

    assign o_full  = (int'(r_cnt) == OQ_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= r_cnt + (PTR_W + 1)'(w_wr) - (PTR_W + 1)'(w_rd);
        end
    end

endmodule

@@ design/mono_lcd_framebuffer_engine_unit.sv @@
// Monochrome LCD frame store, 84 columns by 6 banks of 8 rows, with a built-in
// 5x7 text font. Requests go in through a queue-style port (push/full) and
// every request produces one or more results on a queue-style output port
// (empty/pop), in request order. Pixel set and clear take the request, do
// one read-modify-write of the frame store memory (read, then write), and
// emit the result. A rectangle outline does a read-modify-write (read, then
// write) for each pixel touched, two pixels per column of the horizontal
// edges and two per row of the vertical edges, so up to 264 pixels. A
// character that fits emits its six bytes through the output queue, and a
// valid cursor move its three. A read has a separate memory read state
// before the result because the memory read data is registered. A clear
// store request walks all 504 bytes of the memory one byte per cycle, then
// emits its result. A full output queue holds up the emitting of results
// for as long as it stays full. After reset a clearing pass over all 504
// bytes runs and full stays high until it finishes. The front end accepts
// and range-checks requests into a two-entry queue, so a new request can
// be taken while the back end is still working on an earlier one.
module mono_lcd_framebuffer_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_command,
    input  logic [6:0] i_x_first,
    input  logic [5:0] i_y_first,
    input  logic [6:0] i_x_second,
    input  logic [5:0] i_y_second,
    input  logic [7:0] i_glyph_code,
    input  logic [8:0] i_read_address,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_last,
    output logic [1:0] o_status
);
    import mlfe_pkg::*;

    logic    w_fq_full, w_fq_valid, w_fq_pop;
    logic    w_init, w_res_push, w_oq_full;
    t_item   w_item;
    t_result w_res, w_out;

    // No requests are taken while the reset clearing pass runs.
    assign full = w_fq_full || w_init;

    // Front end: range checks and the request queue.
    mlfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push && !w_init),
        .o_full         (w_fq_full),
        .i_command      (i_command),
        .i_x_first      (i_x_first),
        .i_y_first      (i_y_first),
        .i_x_second     (i_x_second),
        .i_y_second     (i_y_second),
        .i_glyph_code   (i_glyph_code),
        .i_read_address (i_read_address),
        .i_pop          (w_fq_pop),
        .o_valid        (w_fq_valid),
        .o_item         (w_item)
    );

    // Back end: frame store memory, cursor and the drawing sequencer.
    mlfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_fq_valid),
        .i_item     (w_item),
        .o_pop      (w_fq_pop),
        .i_out_full (w_oq_full),
        .o_push     (w_res_push),
        .o_result   (w_res),
        .o_init     (w_init)
    );

    // Result queue toward the consumer.
    mlfe_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out)
    );

    assign o_out_byte = w_out.data_byte;
    assign o_is_data  = w_out.is_data;
    assign o_last     = w_out.last;
    assign o_status   = w_out.status;

endmodule

@@ bench/tb_mono_lcd_framebuffer_engine_unit.sv @@
module tb_mono_lcd_framebuffer_engine_unit;
    import mlfe_pkg::*;

    // Watchdog limit in cycles with no accepted request or result. The
    // limit must outlast the clearing pass after reset, a clear store request
    // and a large rectangle, and a stalled receiver adds to that, so the
    // limit is set with a wide margin.
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] x1;
        logic [5:0] y1;
        logic [6:0] x2;
        logic [5:0] y2;
        logic [7:0] code;
        logic [8:0] addr;
    } t_request;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [2:0] i_command = '0;
    logic [6:0] i_x_first = '0;
    logic [5:0] i_y_first = '0;
    logic [6:0] i_x_second = '0;
    logic [5:0] i_y_second = '0;
    logic [7:0] i_glyph_code = '0;
    logic [8:0] i_read_address = '0;
    logic [7:0] o_out_byte;
    logic       o_is_data;
    logic       o_last;
    logic [1:0] o_status;

    // Requests waiting to be driven, and the results the predictor expects.
    t_request pending_requests[$];
    t_result  expected_bytes[$];

    // The predictor's own copy of the frame store and the text cursor.
    logic [7:0] shadow_store [STORE_BYTES];
    int         shadow_cursor;

    int  error_count;
    int  accepted_requests;
    int  checked_results;
    int  idle_cycles;
    bit  stimulus_done;
    bit  no_idle;

    mono_lcd_framebuffer_engine_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_x_first      (i_x_first),
        .i_y_first      (i_y_first),
        .i_x_second     (i_x_second),
        .i_y_second     (i_y_second),
        .i_glyph_code   (i_glyph_code),
        .i_read_address (i_read_address),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_is_data      (o_is_data),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", checked_results, what);
        error_count++;
    endtask

    function automatic t_result lcd_result(input logic [7:0] b, input logic d,
                                           input logic l, input t_status s);
        t_result r;
        r.data_byte = b;
        r.is_data = d;
        r.last = l;
        r.status = s;
        return r;
    endfunction

    // Font column of a printable code, taken from the packed font table.
    function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
        logic [8*GLYPH_WIDTH-1:0] glyph;
        glyph = FONT[code - CHAR_FIRST];
        return glyph[8*(GLYPH_WIDTH-1-col) +: 8];
    endfunction

    function automatic void paint_pixel(input int x, input int y, input bit on);
        int pos;
        pos = (y / 8) * COLUMNS + x;
        if (pos < STORE_BYTES) begin
            shadow_store[pos][y % 8] = on;
        end
    endfunction

    // Applies one request to the shadow state and queues its results.
    function automatic void predict_lcd_bytes(input t_request rq);
        t_op op;
        bit  on;
        op = t_op'(rq.cmd);
        on = (op == OP_SET || op == OP_DRAW);
        case (op)
            OP_SET, OP_CLR: begin
                if (rq.x1 >= COLUMNS || rq.y1 >= ROWS) begin
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_COORD));
                end else begin
                    paint_pixel(rq.x1, rq.y1, on);
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_OK));
                end
            end
            OP_DRAW, OP_ERASE: begin
                if (rq.x1 >= COLUMNS || rq.y1 >= ROWS || rq.x2 >= COLUMNS || rq.y2 >= ROWS) begin
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_COORD));
                end else begin
                    // An inverted range is empty, so only the other edge pair is drawn.
                    for (int i = rq.x1; i <= rq.x2; i++) begin
                        paint_pixel(i, rq.y1, on);
                        paint_pixel(i, rq.y2, on);
                    end
                    for (int i = rq.y1; i <= rq.y2; i++) begin
                        paint_pixel(rq.x1, i, on);
                        paint_pixel(rq.x2, i, on);
                    end
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_OK));
                end
            end
            OP_CHAR: begin
                if (rq.code < CHAR_FIRST || rq.code > CHAR_LAST) begin
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_CHAR));
                end else if (STORE_BYTES - shadow_cursor < CELL_BYTES) begin
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_OVERFLOW));
                end else begin
                    for (int i = 0; i < CELL_BYTES; i++) begin
                        logic [7:0] b;
                        b = (i < GLYPH_WIDTH) ? font_column(rq.code, i) : 8'h00;
                        shadow_store[shadow_cursor + i] = b;
                        expected_bytes.push_back(lcd_result(b, 1'b1, i == CELL_BYTES - 1, ST_OK));
                    end
                    shadow_cursor += CELL_BYTES;
                end
            end
            OP_MOVE: begin
                if (rq.x1 >= COLUMNS || rq.y1 >= BANKS) begin
                    expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_COORD));
                end else begin
                    shadow_cursor = rq.x1 + rq.y1 * COLUMNS;
                    expected_bytes.push_back(lcd_result(LCD_FUNC_SET, 1'b0, 1'b0, ST_OK));
                    expected_bytes.push_back(lcd_result(LCD_SET_Y | 8'(rq.y1), 1'b0, 1'b0,
                                                        ST_OK));
                    expected_bytes.push_back(lcd_result(LCD_SET_X | 8'(rq.x1), 1'b0, 1'b1,
                                                        ST_OK));
                end
            end
            OP_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = 8'h00;
                expected_bytes.push_back(lcd_result(8'h00, 1'b0, 1'b1, ST_OK));
            end
            default: begin
                if (rq.addr >= STORE_BYTES) begin
                    expected_bytes.push_back(lcd_result(8'h00, 1'b1, 1'b1, ST_COORD));
                end else begin
                    expected_bytes.push_back(lcd_result(shadow_store[rq.addr], 1'b1, 1'b1,
                                                        ST_OK));
                end
            end
        endcase
    endfunction

    function automatic t_request make_request(input t_op op, input int x1, input int y1,
                                              input int x2, input int y2, input int code,
                                              input int addr);
        t_request rq;
        rq.cmd = op;
        rq.x1 = 7'(x1);
        rq.y1 = 6'(y1);
        rq.x2 = 7'(x2);
        rq.y2 = 6'(y2);
        rq.code = 8'(code);
        rq.addr = 9'(addr);
        return rq;
    endfunction

    // Mostly in-range coordinates, sometimes anything the fields allow.
    function automatic t_request random_request();
        t_request rq;
        int       pick;
        rq = make_request(t_op'($urandom_range(0, 7)), 0, 0, 0, 0, 0, 0);
        pick = $urandom_range(0, 9);
        rq.x1 = (pick == 0) ? 7'($urandom) : 7'($urandom_range(0, COLUMNS - 1));
        rq.x2 = (pick == 1) ? 7'($urandom) : 7'($urandom_range(0, COLUMNS - 1));
        rq.y1 = (pick == 2) ? 6'($urandom) : 6'($urandom_range(0, ROWS - 1));
        rq.y2 = (pick == 3) ? 6'($urandom) : 6'($urandom_range(0, ROWS - 1));
        rq.code = (pick == 4) ? 8'($urandom) : 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
        rq.addr = (pick == 5) ? 9'($urandom) : 9'($urandom_range(0, STORE_BYTES - 1));
        if (t_op'(rq.cmd) == OP_MOVE && pick > 5) begin
            rq.y1 = 6'($urandom_range(0, BANKS - 1));
        end
        // Clearing is slow; keep it rare.
        if (t_op'(rq.cmd) == OP_CLEAR && $urandom_range(0, 3) != 0) begin
            rq.cmd = OP_READ;
        end
        return rq;
    endfunction

    // Stimulus: a directed pass over the edges and special cases, then random
    // requests. Runs of characters after a cursor move exercise text output.
    initial begin
        pending_requests.push_back(make_request(OP_SET, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SET, COLUMNS - 1, ROWS - 1, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SET, 127, 63, 127, 63, 255, 511));
        pending_requests.push_back(make_request(OP_CLR, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 511));
        pending_requests.push_back(make_request(OP_DRAW, 0, 0, COLUMNS - 1, ROWS - 1, 0, 0));
        pending_requests.push_back(make_request(OP_DRAW, 20, 30, 10, 5, 0, 0));
        pending_requests.push_back(make_request(OP_DRAW, 5, 40, 50, 2, 0, 0));
        pending_requests.push_back(make_request(OP_ERASE, 0, 0, COLUMNS, 0, 0, 0));
        pending_requests.push_back(make_request(OP_ERASE, 0, 0, COLUMNS - 1, ROWS - 1, 0, 0));
        pending_requests.push_back(make_request(OP_MOVE, COLUMNS - 1, BANKS, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_MOVE, 127, 63, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_MOVE, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, CHAR_FIRST, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, CHAR_LAST, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, 8'h1F, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, 8'hFF, 0));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 7));
        // The last cell fits at column 78 of the bottom bank; the next overflows.
        pending_requests.push_back(make_request(OP_MOVE, COLUMNS - 6, BANKS - 1, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, 8'h41, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, 8'h42, 0));
        pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0, 8'h10, 0));
        pending_requests.push_back(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        while (pending_requests.size() < 195) begin
            if ($urandom_range(0, 4) == 0) begin
                pending_requests.push_back(make_request(OP_MOVE, $urandom_range(0, COLUMNS - 1),
                    $urandom_range(0, BANKS - 1), 0, 0, 0, 0));
                repeat ($urandom_range(1, 6)) begin
                    pending_requests.push_back(make_request(OP_CHAR, 0, 0, 0, 0,
                        $urandom_range(CHAR_FIRST, CHAR_LAST), 0));
                end
            end else begin
                pending_requests.push_back(random_request());
            end
        end
    end

    initial begin
        foreach (shadow_store[i]) shadow_store[i] = 8'h00;
        shadow_cursor = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Idling is disabled for a stretch in the middle of the run.
    always @(posedge i_clk) begin
        no_idle <= (accepted_requests >= 80 && accepted_requests < 130);
    end

    // Driver: one request is offered at a time and held until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_lcd_bytes({i_command, i_x_first, i_y_first, i_x_second, i_y_second,
                                   i_glyph_code, i_read_address});
                accepted_requests++;
            end
            if ((!push || !full) ) begin
                if (pending_requests.size() > 0 && (no_idle || $urandom_range(0, 99) >= 33))
                begin
                    t_request rq;
                    rq = pending_requests.pop_front();
                    push <= 1'b1;
                    i_command <= rq.cmd;
                    i_x_first <= rq.x1;
                    i_y_first <= rq.y1;
                    i_x_second <= rq.x2;
                    i_y_second <= rq.y2;
                    i_glyph_code <= rq.code;
                    i_read_address <= rq.addr;
                end else begin
                    push <= 1'b0;
                    if (pending_requests.size() == 0) stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %02h", o_out_byte));
                end else begin
                    t_result want;
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data_byte)
                        report_mismatch($sformatf("out_byte %02h, want %02h", o_out_byte,
                                                  want.data_byte));
                    if (o_is_data !== want.is_data)
                        report_mismatch($sformatf("is_data %b, want %b", o_is_data,
                                                  want.is_data));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", o_last, want.last));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", o_status,
                                                  want.status));
                end
                checked_results++;
            end
            pop <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    // Watchdog and end of run.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results still expected", expected_bytes.size());
            $display("tb_mono_lcd_framebuffer_engine_unit: errors");
            $finish;
        end else if (stimulus_done && !push && expected_bytes.size() == 0 && idle_cycles >= 600)
        begin
            // The end also waits for a quiet stretch with no accepted request or result.
            $display("covered %0d requests and %0d result bytes, all commands and error cases",
                     accepted_requests, checked_results);
            if (error_count == 0) begin
                $display("tb_mono_lcd_framebuffer_engine_unit: clean");
            end else begin
                $display("tb_mono_lcd_framebuffer_engine_unit: errors");
            end
            $finish;
        end
    end

endmodule

@@ mono_lcd_framebuffer_engine_unit.f @@
+incdir+design
design/mlfe_pkg.sv
design/mlfe_front.sv
design/mlfe_back.sv
design/mlfe_outq.sv
design/mono_lcd_framebuffer_engine_unit.sv
bench/tb_mono_lcd_framebuffer_engine_unit.sv
